// File: rtl/pfcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfcb_pkg;

  typedef enum logic [2:0] {
    FMT_ARGB = 3'd0,
    FMT_RGB  = 3'd1,
    FMT_RGBA = 3'd2,
    FMT_ABGR = 3'd3,
    FMT_BGR  = 3'd4
  } fmt_e;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_BLEND   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_CONV  = 2'd1,
    KIND_BLEND = 2'd2
  } kind_e;

  typedef logic [7:0] chan_t;
  // [0] red, [1] green, [2] blue, [3] alpha
  typedef chan_t [3:0] pix_ch_t;

  localparam int unsigned NumChan = 4;
  localparam chan_t       ChanMax = 8'hFF;

  function automatic logic fmt_valid(logic [2:0] fmt);
    logic ok;
    ok = 1'b0;
    unique case (fmt)
      FMT_ARGB, FMT_RGB, FMT_RGBA, FMT_ABGR, FMT_BGR: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Formats without alpha read as opaque.
  function automatic pix_ch_t unpack(logic [2:0] fmt, logic [31:0] px);
    pix_ch_t ch;
    ch = '0;
    unique case (fmt)
      FMT_ARGB: ch = {px[31:24], px[7:0], px[15:8], px[23:16]};
      FMT_RGB:  ch = {ChanMax, px[7:0], px[15:8], px[23:16]};
      FMT_RGBA: ch = {px[7:0], px[15:8], px[23:16], px[31:24]};
      FMT_ABGR: ch = px;
      FMT_BGR:  ch = {ChanMax, px[23:0]};
      default:  ch = '0;
    endcase
    return ch;
  endfunction

  function automatic logic [31:0] pack(logic [2:0] fmt, pix_ch_t ch);
    logic [31:0] px;
    px = '0;
    unique case (fmt)
      FMT_ARGB: px = {ch[3], ch[0], ch[1], ch[2]};
      FMT_RGB:  px = {8'h00, ch[0], ch[1], ch[2]};
      FMT_RGBA: px = {ch[0], ch[1], ch[2], ch[3]};
      FMT_ABGR: px = {ch[3], ch[2], ch[1], ch[0]};
      FMT_BGR:  px = {8'h00, ch[2], ch[1], ch[0]};
      default:  px = '0;
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pfcb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pfcb_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  source_format;
  logic [31:0] source_pixel;
  logic [31:0] dest_pixel;

  modport source (
    output valid, cmd, source_format, source_pixel, dest_pixel,
    input  ready
  );
  modport sink (
    input  valid, cmd, source_format, source_pixel, dest_pixel,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/pfcb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pfcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;
  logic        write_enable;

  modport source (
    output valid, result_pixel, write_enable,
    input  ready
  );
  modport sink (
    input  valid, result_pixel, write_enable,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/pfcb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel of source-over: registered s*a + d*(255-a) + 127, then /255.
module pfcb_lane (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire pfcb_pkg::chan_t s_i,
  input  wire pfcb_pkg::chan_t d_i,
  input  wire pfcb_pkg::chan_t a_i,
  output pfcb_pkg::chan_t    q_o
);

  logic [15:0] sum_d, sum_q;
  logic [15:0] fold;

  assign sum_d = {8'h00, s_i} * {8'h00, a_i}
               + {8'h00, d_i} * {8'h00, pfcb_pkg::ChanMax - a_i} + 16'd127;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // exact x/255 for x up to 255*255+127
  assign fold = sum_q + {8'h00, sum_q[15:8]} + 16'd1;
  assign q_o  = fold[15:8];

endmodule

`default_nettype wire

// File: rtl/pixel_format_convert_blend_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake        payload
// cfg       in   cfg_we_i         cfg_wdata_i (dest_format)
// in_i      in   valid / ready    cmd, source_format, source_pixel, dest_pixel
// out_o     out  valid / ready    result_pixel, write_enable
//
// One word per cycle while out_o is not stalled; register stages for unpack,
// per-channel multiply-add, and divide by 255 and pack, each with its own valid bit.
// Reset clears the valid bits and sets dest_format to ARGB.
// A stage advances when empty or when the next one advances, so bubbles
// are filled while out_o is stalled and nothing is dropped or repeated.
module pixel_format_convert_blend_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  pfcb_in_if.sink         in_i,
  pfcb_out_if.source      out_o
);

  logic [2:0] dfmt_q;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  pfcb_pkg::kind_e   kind1_d, kind1_q, kind2_q;
  pfcb_pkg::pix_ch_t s_ch, d_ch, s1_q, d1_q;
  pfcb_pkg::chan_t   a1_q;
  logic [31:0]       conv1_d, conv1_q, conv2_q;
  logic [2:0]        fmt1_q, fmt2_q;
  pfcb_pkg::pix_ch_t mixed;

  logic [31:0] result_d, result_q;
  logic        we_d, we_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfmt_q <= pfcb_pkg::FMT_ARGB;
    end else if (cfg_we_i) begin
      dfmt_q <= cfg_wdata_i;
    end
  end

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: unpack and classify
  assign s_ch = pfcb_pkg::unpack(in_i.source_format, in_i.source_pixel);
  assign d_ch = pfcb_pkg::unpack(dfmt_q, in_i.dest_pixel);

  always_comb begin
    kind1_d = pfcb_pkg::KIND_DROP;
    if (pfcb_pkg::fmt_valid(in_i.source_format) && pfcb_pkg::fmt_valid(dfmt_q)) begin
      if (in_i.cmd == pfcb_pkg::CMD_CONVERT) begin
        kind1_d = pfcb_pkg::KIND_CONV;
      end else if (s_ch[3] != '0) begin
        kind1_d = pfcb_pkg::KIND_BLEND;
      end
    end
  end

  assign conv1_d = (in_i.source_format == dfmt_q) ? in_i.source_pixel
                                                  : pfcb_pkg::pack(dfmt_q, s_ch);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind1_q <= kind1_d;
      conv1_q <= conv1_d;
      fmt1_q  <= dfmt_q;
      a1_q    <= s_ch[3];
      s1_q    <= {pfcb_pkg::ChanMax, s_ch[2:0]};
      d1_q    <= d_ch;
    end
  end

  // stage 2: per-channel multiply-add, divide in front of stage 3
  for (genvar i = 0; i < pfcb_pkg::NumChan; i++) begin : g_lane
    pfcb_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en2),
      .s_i   (s1_q[i]),
      .d_i   (d1_q[i]),
      .a_i   (a1_q),
      .q_o   (mixed[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      kind2_q <= kind1_q;
      conv2_q <= conv1_q;
      fmt2_q  <= fmt1_q;
    end
  end

  // stage 3: select and pack
  always_comb begin
    result_d = '0;
    we_d     = 1'b0;
    unique case (kind2_q)
      pfcb_pkg::KIND_CONV: begin
        result_d = conv2_q;
        we_d     = 1'b1;
      end
      pfcb_pkg::KIND_BLEND: begin
        result_d = pfcb_pkg::pack(fmt2_q, mixed);
        we_d     = 1'b1;
      end
      default: begin
        result_d = '0;
        we_d     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      result_q <= result_d;
      we_q     <= we_d;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.result_pixel = result_q;
  assign out_o.write_enable = we_q;

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.write_enable |-> out_o.result_pixel == '0)
    else $error("dropped word carries nonzero pixel");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!v1_q || !v2_q || !v3_q || out_o.ready))
    else $error("input ready disagrees with pipeline occupancy");

  a_blend_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && kind1_q == pfcb_pkg::KIND_BLEND |-> a1_q != '0)
    else $error("blend issued with transparent source");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldLen     = 300;
  localparam int unsigned PhaseLen    = 195;
  localparam int unsigned BadPhaseLen = 40;
  localparam int unsigned DrainCycles = 8;
  localparam logic [2:0]  FmtBadFirst = 3'd5;
  localparam logic [2:0]  FmtBadLast  = 3'd7;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        write_enable;
  } pixel_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  pfcb_in_if  in_if ();
  pfcb_out_if out_if ();

  pixel_format_convert_blend_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  pixel_word_t expected_pixels[$];
  logic [2:0]  dest_format_q;
  bit          sender_quiet;
  bit          sink_quiet;
  int unsigned hold_cycles;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned cfg_writes;
  int unsigned errors;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic bit fmt_has_alpha(logic [2:0] f);
    return !(f == pfcb_pkg::FMT_RGB || f == pfcb_pkg::FMT_BGR);
  endfunction

  function automatic rgba_t split_pixel(logic [2:0] f, logic [31:0] px);
    rgba_t c;
    case (f)
      pfcb_pkg::FMT_ARGB: c = {px[23:16], px[15:8], px[7:0], px[31:24]};
      pfcb_pkg::FMT_RGB:  c = {px[23:16], px[15:8], px[7:0], 8'hFF};
      pfcb_pkg::FMT_RGBA: c = px;
      pfcb_pkg::FMT_ABGR: c = {px[7:0], px[15:8], px[23:16], px[31:24]};
      default:            c = {px[7:0], px[15:8], px[23:16], 8'hFF};
    endcase
    return c;
  endfunction

  function automatic logic [31:0] join_pixel(logic [2:0] f, rgba_t c);
    logic [31:0] px;
    case (f)
      pfcb_pkg::FMT_ARGB: px = {c.a, c.r, c.g, c.b};
      pfcb_pkg::FMT_RGB:  px = {8'h00, c.r, c.g, c.b};
      pfcb_pkg::FMT_RGBA: px = c;
      pfcb_pkg::FMT_ABGR: px = {c.a, c.b, c.g, c.r};
      default:            px = {8'h00, c.b, c.g, c.r};
    endcase
    return px;
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int unsigned t;
    t = (32'(s) * 32'(a) + 32'(d) * (32'd255 - 32'(a)) + 32'd127) / 32'd255;
    return t[7:0];
  endfunction

  function automatic pixel_word_t predict_pixel(logic cmd, logic [2:0] sf, logic [31:0] spx,
                                                logic [31:0] dpx, logic [2:0] df);
    pixel_word_t w;
    rgba_t       s;
    rgba_t       d;
    rgba_t       o;
    w = '0;
    if (sf <= pfcb_pkg::FMT_BGR && df <= pfcb_pkg::FMT_BGR) begin
      s = split_pixel(sf, spx);
      if (cmd == pfcb_pkg::CMD_CONVERT) begin
        w.pixel = (sf == df) ? spx : join_pixel(df, s);
        w.write_enable = 1'b1;
      end else if (s.a != 8'h00) begin
        d   = split_pixel(df, dpx);
        o.r = mix8(s.r, d.r, s.a);
        o.g = mix8(s.g, d.g, s.a);
        o.b = mix8(s.b, d.b, s.a);
        o.a = fmt_has_alpha(df) ? mix8(8'hFF, d.a, s.a) : 8'hFF;
        w.pixel = join_pixel(df, o);
        w.write_enable = 1'b1;
      end
    end
    return w;
  endfunction

  task automatic send_word(logic cmd, logic [2:0] sf, logic [31:0] spx, logic [31:0] dpx);
    int unsigned gap;
    gap = idle_len(sender_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.cmd           = cmd;
    in_if.source_format = sf;
    in_if.source_pixel  = spx;
    in_if.dest_pixel    = dpx;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    expected_pixels.push_back(predict_pixel(cmd, sf, spx, dpx, dest_format_q));
    sent_count++;
  endtask

  task automatic send_random_word();
    logic        cmd;
    logic [2:0]  sf;
    logic [31:0] spx;
    logic [31:0] dpx;
    logic [7:0]  a;
    int unsigned r;
    cmd = 1'($urandom_range(0, 1));
    r   = $urandom_range(0, 99);
    sf  = (r < 90) ? 3'($urandom_range(pfcb_pkg::FMT_ARGB, pfcb_pkg::FMT_BGR))
                   : 3'($urandom_range(FmtBadFirst, FmtBadLast));
    spx = $urandom;
    dpx = $urandom;
    r   = $urandom_range(0, 99);
    a   = (r < 15) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom_range(0, 255));
    if (sf == pfcb_pkg::FMT_RGBA) spx[7:0] = a;
    else spx[31:24] = a;
    r = $urandom_range(0, 99);
    if (r < 3) dpx = '0;
    else if (r < 6) dpx = '1;
    send_word(cmd, sf, spx, dpx);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_dest_format(logic [2:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we        = 1'b0;
    dest_format_q = v;
    cfg_writes++;
  endtask

  // dest_format left at its reset value
  task automatic test_reset_format();
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_ARGB, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_RGB,  32'hAB12_3456, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_RGBA, 32'h1122_3344, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_ABGR, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_BGR,  32'hFFFF_FFFF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ARGB, 32'h00FF_FFFF, 32'h1234_5678);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ARGB, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ARGB, 32'h80FF_0000, 32'h4000_FF00);
    send_word(pfcb_pkg::CMD_CONVERT, FmtBadFirst, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   FmtBadLast,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_dest_formats();
    write_dest_format(pfcb_pkg::FMT_RGB);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_RGB,  32'hFFFF_FFFF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ARGB, 32'h7F10_2030, 32'hFFFF_FFFF);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_BGR,  32'h00AA_BBCC, 32'h0011_2233);
    write_dest_format(pfcb_pkg::FMT_RGBA);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_ABGR, 32'h8844_2211, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_RGBA, 32'hFFFF_FF01, 32'h0000_0080);
    write_dest_format(pfcb_pkg::FMT_ABGR);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_RGB,  32'hFF00_FF00, 32'h5555_5555);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_ARGB, 32'hC012_3456, 32'h0000_0000);
    write_dest_format(pfcb_pkg::FMT_BGR);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_RGBA, 32'h1234_56FF, 32'h0000_0000);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ABGR, 32'h40FF_FFFF, 32'hFF00_0000);
    write_dest_format(FmtBadFirst);
    send_word(pfcb_pkg::CMD_CONVERT, pfcb_pkg::FMT_ARGB, 32'hFFFF_FFFF, 32'h0000_0000);
    write_dest_format(FmtBadLast);
    send_word(pfcb_pkg::CMD_BLEND,   pfcb_pkg::FMT_ARGB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // output held off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    write_dest_format(pfcb_pkg::FMT_ABGR);
    sender_quiet = 1'b1;
    sink_quiet   = 1'b0;
    @(posedge clk_i);
    hold_cycles = HoldLen;
    repeat (60) send_random_word();
    sender_quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [2:0]  f;
    int unsigned n;
    for (int p = 0; p < 10; p++) begin
      if (p < 5) f = 3'(p);
      else if (p == 5) f = FmtBadLast;
      else f = 3'($urandom_range(0, 7));
      write_dest_format(f);
      sender_quiet = (p % 4 == 1) || (p % 4 == 3);
      sink_quiet   = (p % 4 >= 2);
      n = (f > pfcb_pkg::FMT_BGR) ? BadPhaseLen : PhaseLen;
      repeat (n) send_random_word();
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  initial begin : sink_drive
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = rst_ni;
        stall = idle_len(sink_quiet);
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_word_t e;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected word: result_pixel %h write_enable %b",
               out_if.result_pixel, out_if.write_enable);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        checked_count++;
        if (out_if.result_pixel !== e.pixel) begin
          $error("result_pixel: expected %h, got %h", e.pixel, out_if.result_pixel);
          errors++;
        end
        if (out_if.write_enable !== e.write_enable) begin
          $error("write_enable: expected %b, got %b", e.write_enable, out_if.write_enable);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("timeout: no handshake for %0d cycles", IdleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.cmd           = pfcb_pkg::CMD_CONVERT;
    in_if.source_format = pfcb_pkg::FMT_ARGB;
    in_if.source_pixel  = '0;
    in_if.dest_pixel    = '0;
    dest_format_q       = pfcb_pkg::FMT_ARGB;
    sender_quiet        = 1'b0;
    sink_quiet          = 1'b0;
    hold_cycles         = 0;
    sent_count          = 0;
    checked_count       = 0;
    cfg_writes          = 0;
    errors              = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_format();
    test_dest_formats();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (expected_pixels.size() != 0) begin
      $error("%0d expected words never arrived", expected_pixels.size());
      errors++;
    end
    $display("Sent %0d words, checked %0d, across %0d dest_format writes, valid and bad codes.",
             sent_count, checked_count, cfg_writes);
    $display("Convert and blend, bad format codes, random gaps, one %0d-cycle output stall.",
             HoldLen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: pixel_format_convert_blend_core.f
rtl/pfcb_pkg.sv
rtl/pfcb_in_if.sv
rtl/pfcb_out_if.sv
rtl/pfcb_lane.sv
rtl/pixel_format_convert_blend_core.sv
tb/testbench.sv
